FILE: rtl/core/mpfp_pkg.sv
`default_nettype none

package mpfp_pkg;

    // screen geometry
    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;

    localparam int COL_W  = $clog2(SCREEN_WIDTH);
    localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
    localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

    // field widths
    localparam int OP_W     = 2;
    localparam int XPOS_W   = 9;
    localparam int YPOS_W   = 8;
    localparam int RWIDTH_W = 8;
    localparam int RHEIGHT_W = 7;
    localparam int ADDR_W   = 10;
    localparam int DATA_W   = 8;
    localparam int MODE_W   = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_PLOT  = 2'd0;
    localparam logic [OP_W-1:0] OP_FILL  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_READ  = 2'd3;

    // color modes
    localparam logic [MODE_W-1:0] MODE_SET    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLR    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TOGGLE = 2'd2;

    // byte address of a column within a page
    function automatic logic [ADDR_W-1:0] byte_addr(input logic [PAGE_W-1:0] page,
                                                    input logic [COL_W-1:0]  col);
        logic [ADDR_W+COL_W:0] sum;
        begin
            sum = (ADDR_W+COL_W+1)'(page) * (ADDR_W+COL_W+1)'(SCREEN_WIDTH)
                + (ADDR_W+COL_W+1)'(col);
            return sum[ADDR_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mpfp_if.sv
`default_nettype none

// command channel
interface mpfp_cmd_if;
    logic                                   valid;
    logic                                   ready;
    logic        [mpfp_pkg::OP_W-1:0]       op;
    logic signed [mpfp_pkg::XPOS_W-1:0]     x_pos;
    logic signed [mpfp_pkg::YPOS_W-1:0]     y_pos;
    logic        [mpfp_pkg::RWIDTH_W-1:0]   rect_width;
    logic        [mpfp_pkg::RHEIGHT_W-1:0]  rect_height;
    logic        [mpfp_pkg::ADDR_W-1:0]     byte_address;

    modport source (output valid, op, x_pos, y_pos, rect_width, rect_height, byte_address,
                    input ready);
    modport sink   (input valid, op, x_pos, y_pos, rect_width, rect_height, byte_address,
                    output ready);
endinterface

// read response channel
interface mpfp_rd_if;
    logic                          valid;
    logic                          ready;
    logic [mpfp_pkg::DATA_W-1:0]   read_data;

    modport source (output valid, read_data, input ready);
    modport sink   (input valid, read_data, output ready);
endinterface

// configuration write channel
interface mpfp_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mpfp_pkg::MODE_W-1:0]   color_mode;

    modport source (output valid, color_mode, input ready);
    modport sink   (input valid, color_mode, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/mono_page_framebuffer_plotter.sv
// Plot: read-modify-write of one store byte; an off-screen pixel is dropped.
// Read: the byte passes through the store's read register into an output register, where read_data is held until taken.
// Fill: the clipped columns of each touched page, one store byte per cycle; an empty rectangle writes nothing.
// Clear: a sweep counter writes zero to every store byte, one byte written per cycle.
// Reset: asynchronous active low; a clearing sweep runs first, during
// which cmd.ready stays low. color_mode resets to set.
`default_nettype none

module mono_page_framebuffer_plotter (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mpfp_cmd_if.sink    cmd,
    mpfp_rd_if.source   rsp,
    mpfp_cfg_if.sink    cfg
);
    import mpfp_pkg::*;

    // sequencer states
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_FILL  = 2'd2;
    localparam logic [1:0] ST_READ  = 2'd3;

    localparam int CW = 11;  // signed width for clipping arithmetic
    localparam logic signed [CW-1:0] SCR_W_S = CW'(SCREEN_WIDTH);
    localparam logic signed [CW-1:0] SCR_H_S = CW'(SCREEN_HEIGHT);
    localparam logic [ADDR_W-1:0] LAST_BYTE = ADDR_W'(STORE_BYTES - 1);

    // ------------------------------------------------------------------
    // Frame store: one write port, one registered read port.
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] store_mem [STORE_BYTES];
    logic [DATA_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] mem_raddr;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_we;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= store_mem[mem_raddr];
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [1:0]         state_reg, state_next;
    logic [ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [MODE_W-1:0]  mode_reg, mode_next;

    // fill walker
    logic [COL_W-1:0]   col_reg, col_next;
    logic [COL_W-1:0]   col_first_reg, col_first_next;
    logic [COL_W-1:0]   col_last_reg, col_last_next;
    logic [PAGE_W-1:0]  page_reg, page_next;
    logic [PAGE_W-1:0]  page_first_reg, page_first_next;
    logic [PAGE_W-1:0]  page_last_reg, page_last_next;
    logic [2:0]         row_first_reg, row_first_next;
    logic [2:0]         row_last_reg, row_last_next;

    // pending write-back of the byte read last cycle
    logic               pend_reg, pend_next;
    logic [ADDR_W-1:0]  wr_addr_reg, wr_addr_next;
    logic [DATA_W-1:0]  wr_mask_reg, wr_mask_next;

    // read op and output register
    logic [ADDR_W-1:0]  rd_addr_reg, rd_addr_next;
    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  out_data_reg, out_data_next;

    // ------------------------------------------------------------------
    // Command decode and clipping (used in idle)
    // ------------------------------------------------------------------
    logic signed [CW-1:0] x_s, y_s, x_end, y_end;
    logic signed [CW-1:0] x_lo, x_hi, y_lo, y_hi, x_hi_m1, y_hi_m1;
    logic                 fill_ok, plot_ok;
    logic [COL_W-1:0]     plot_col;
    logic [ROW_W-1:0]     plot_row, fill_row_lo, fill_row_hi;
    logic [PAGE_W-1:0]    plot_page;
    logic [ADDR_W-1:0]    plot_addr, fill_addr;
    logic [DATA_W-1:0]    fill_mask;
    logic [2:0]           mask_lo, mask_hi;
    logic                 cmd_fire, out_free, fill_last_col;

    assign x_s   = CW'(cmd.x_pos);
    assign y_s   = CW'(cmd.y_pos);
    assign x_end = x_s + $signed({3'b000, cmd.rect_width});
    assign y_end = y_s + $signed({4'b0000, cmd.rect_height});
    assign x_lo  = x_s[CW-1] ? '0 : x_s;
    assign y_lo  = y_s[CW-1] ? '0 : y_s;
    assign x_hi  = (x_end > SCR_W_S) ? SCR_W_S : x_end;
    assign y_hi  = (y_end > SCR_H_S) ? SCR_H_S : y_end;
    assign x_hi_m1 = x_hi - CW'(1);
    assign y_hi_m1 = y_hi - CW'(1);
    assign fill_ok = (x_hi > x_lo) && (y_hi > y_lo);
    assign fill_row_lo = y_lo[ROW_W-1:0];
    assign fill_row_hi = y_hi_m1[ROW_W-1:0];

    // pixel is on screen when both coordinates fall in range
    assign plot_ok   = !x_s[CW-1] && (x_s < SCR_W_S) && !y_s[CW-1] && (y_s < SCR_H_S);
    assign plot_col  = x_s[COL_W-1:0];
    assign plot_row  = y_s[ROW_W-1:0];
    assign plot_page = PAGE_W'(plot_row >> 3);
    assign plot_addr = byte_addr(plot_page, plot_col);

    // fill byte at the walker position; mask covers the rows of this page in range
    assign fill_addr = byte_addr(page_reg, col_reg);
    assign mask_lo   = (page_reg == page_first_reg) ? row_first_reg : 3'd0;
    assign mask_hi   = (page_reg == page_last_reg)  ? row_last_reg  : 3'd7;
    assign fill_mask = (8'hFF << mask_lo) & (8'hFF >> (3'd7 - mask_hi));
    assign fill_last_col = (col_reg == col_last_reg);

    // writes back one byte at a time; a new command waits out a pending write
    assign cmd.ready = (state_reg == ST_IDLE) && !pend_reg;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;

    // ------------------------------------------------------------------
    // Write port: clearing sweep or modified byte
    // ------------------------------------------------------------------
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wr_addr_reg;
        mem_wdata = rd_data_reg;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else if (pend_reg)
        begin
            mem_we = 1'b1;
            unique case (mode_reg)
                MODE_SET:    mem_wdata = rd_data_reg | wr_mask_reg;
                MODE_CLR:    mem_wdata = rd_data_reg & ~wr_mask_reg;
                MODE_TOGGLE: mem_wdata = rd_data_reg ^ wr_mask_reg;
                default:     mem_wdata = rd_data_reg;  // fourth mode leaves store as is
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        mode_next       = mode_reg;
        col_next        = col_reg;
        col_first_next  = col_first_reg;
        col_last_next   = col_last_reg;
        page_next       = page_reg;
        page_first_next = page_first_reg;
        page_last_next  = page_last_reg;
        row_first_next  = row_first_reg;
        row_last_next   = row_last_reg;
        pend_next       = 1'b0;
        wr_addr_next    = wr_addr_reg;
        wr_mask_next    = wr_mask_reg;
        rd_addr_next    = rd_addr_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_data_next   = out_data_reg;
        mem_raddr       = cmd.byte_address;

        if (cfg.valid)
        begin
            mode_next = cfg.color_mode;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == LAST_BYTE)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (cmd.op == OP_PLOT)
                begin
                    mem_raddr = plot_addr;
                end
                if (cmd_fire)
                begin
                    unique case (cmd.op)
                        OP_PLOT:
                        begin
                            // read now, write back next cycle; off screen drops it
                            pend_next    = plot_ok;
                            wr_addr_next = plot_addr;
                            wr_mask_next = DATA_W'(1) << plot_row[2:0];
                        end
                        OP_FILL:
                        begin
                            if (fill_ok)
                            begin
                                col_first_next  = x_lo[COL_W-1:0];
                                col_next        = x_lo[COL_W-1:0];
                                col_last_next   = x_hi_m1[COL_W-1:0];
                                page_first_next = PAGE_W'(fill_row_lo >> 3);
                                page_next       = PAGE_W'(fill_row_lo >> 3);
                                page_last_next  = PAGE_W'(fill_row_hi >> 3);
                                row_first_next  = fill_row_lo[2:0];
                                row_last_next   = fill_row_hi[2:0];
                                state_next      = ST_FILL;
                            end
                        end
                        OP_CLEAR:
                        begin
                            clr_cnt_next = '0;
                            state_next   = ST_CLEAR;
                        end
                        default:
                        begin
                            // read byte: data arrives next cycle
                            rd_addr_next = cmd.byte_address;
                            state_next   = ST_READ;
                        end
                    endcase
                end
            end

            ST_FILL:
            begin
                // one read per cycle, written back through the pending write-back registers; addresses never repeat
                mem_raddr    = fill_addr;
                pend_next    = 1'b1;
                wr_addr_next = fill_addr;
                wr_mask_next = fill_mask;
                if (fill_last_col)
                begin
                    col_next = col_first_reg;
                    if (page_reg == page_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        page_next = page_reg + PAGE_W'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end

            default:
            begin
                // ST_READ: address held so the byte stays valid while the output is full
                mem_raddr = rd_addr_reg;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = ({1'b0, rd_addr_reg} < (ADDR_W+1)'(STORE_BYTES))
                                     ? rd_data_reg : '0;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            mode_reg      <= MODE_SET;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            mode_reg      <= mode_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg        <= col_next;
        col_first_reg  <= col_first_next;
        col_last_reg   <= col_last_next;
        page_reg       <= page_next;
        page_first_reg <= page_first_next;
        page_last_reg  <= page_last_next;
        row_first_reg  <= row_first_next;
        row_last_reg   <= row_last_next;
        wr_addr_reg    <= wr_addr_next;
        wr_mask_reg    <= wr_mask_next;
        rd_addr_reg    <= rd_addr_next;
        out_data_reg   <= out_data_next;
    end

endmodule

`default_nettype wire
